/* rtl/core/pso_pkg.sv */
package pso_pkg;

  localparam int DEF_MAX_PARTICLES = 64;
  localparam int DEF_MAX_DIMS      = 64;
  localparam int DEF_GROUP_STRIDE  = 3;

  localparam logic [15:0]        RST_INERTIA   = 16'd6554;
  localparam logic [17:0]        RST_LOCAL     = 18'd131072;
  localparam logic [17:0]        RST_SOCIAL    = 18'd131072;
  localparam logic signed [31:0] RST_CLAMP_LO  = 32'sd13107;
  localparam logic signed [31:0] RST_CLAMP_HI  = 32'sd52429;
  localparam logic               RST_CLAMP_EN  = 1'b1;
  localparam logic [6:0]         RST_DIMS      = 7'd12;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_FIT  = 2'd1,
    CMD_UPD  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_INERTIA   = 3'd0,
    REG_LOCAL     = 3'd1,
    REG_SOCIAL    = 3'd2,
    REG_CLAMP_LO  = 3'd3,
    REG_CLAMP_HI  = 3'd4,
    REG_CLAMP_EN  = 3'd5,
    REG_DIMS      = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_t;

  typedef struct packed {
    cmd_t               cmd;
    logic               in_range;
    logic               clamp_slot;
    logic [5:0]         particle;
    logic [5:0]         dimension;
    logic signed [31:0] load_value;
    logic [31:0]        fitness;
    logic [15:0]        rand_inertia;
    logic [15:0]        rand_local;
    logic [15:0]        rand_social;
  } item_t;

  typedef struct packed {
    logic signed [31:0] new_position;
    logic signed [31:0] new_velocity;
    logic               became_global;
    logic               became_local;
    logic [5:0]         leader;
  } result_t;

  typedef struct packed {
    logic [15:0]        inertia_gain;
    logic [17:0]        local_gain;
    logic [17:0]        social_gain;
    logic signed [31:0] clamp_low;
    logic signed [31:0] clamp_high;
    logic               clamp_enable;
    logic [6:0]         dims_in_use;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
    logic signed [31:0] r;
    if (x > 38'sd2147483647) r = 32'sh7fffffff;
    else if (x < -38'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

/* rtl/core/pso_front.sv */
module pso_front #(
  parameter int MAX_PARTICLES = pso_pkg::DEF_MAX_PARTICLES,
  parameter int MAX_DIMS      = pso_pkg::DEF_MAX_DIMS,
  parameter int GROUP_STRIDE  = pso_pkg::DEF_GROUP_STRIDE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_command,
  input  logic [5:0]         in_particle,
  input  logic [5:0]         in_dimension,
  input  logic signed [31:0] in_load_value,
  input  logic [31:0]        in_fitness,
  input  logic [15:0]        in_rand_inertia,
  input  logic [15:0]        in_rand_local,
  input  logic [15:0]        in_rand_social,
  output logic               q_valid,
  output pso_pkg::item_t     q_item,
  input  logic               q_pop
);

  pso_pkg::item_t cls;
  pso_pkg::item_t buf_r [2];
  logic           wptr_r, rptr_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push_ok;

  // classify: range check and clamp group membership
  always_comb begin
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 64; k++) begin
      if (int'(in_dimension) == k * GROUP_STRIDE) hit = 1'b1;
    end
    cls.cmd          = pso_pkg::cmd_t'(in_command);
    cls.in_range     = (int'(in_particle) < MAX_PARTICLES) && (int'(in_dimension) < MAX_DIMS);
    cls.clamp_slot   = hit;
    cls.particle     = in_particle;
    cls.dimension    = in_dimension;
    cls.load_value   = in_load_value;
    cls.fitness      = in_fitness;
    cls.rand_inertia = in_rand_inertia;
    cls.rand_local   = in_rand_local;
    cls.rand_social  = in_rand_social;
  end

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = buf_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !(q_pop && q_valid)) cnt_nxt = cnt_r + 2'd1;
    else if (!push_ok && q_pop && q_valid) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) wptr_r <= ~wptr_r;
      if (q_pop && q_valid) rptr_r <= ~rptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) buf_r[wptr_r] <= cls;
  end

endmodule

/* rtl/core/pso_rsp_queue.sv */
module pso_rsp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rsp_push,
  output logic               rsp_full,
  input  pso_pkg::result_t   rsp_data,
  output logic               out_empty,
  input  logic               out_pop,
  output pso_pkg::result_t   out_data
);

  pso_pkg::result_t buf_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             wr, rd;

  assign rsp_full  = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign wr        = rsp_push && !rsp_full;
  assign rd        = out_pop && !out_empty;
  assign out_data  = buf_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) cnt_nxt = cnt_r + 2'd1;
    else if (!wr && rd) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr) wptr_r <= ~wptr_r;
      if (rd) rptr_r <= ~rptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) buf_r[wptr_r] <= rsp_data;
  end

endmodule

/* rtl/core/pso_back.sv */
module pso_back #(
  parameter int MAX_PARTICLES = pso_pkg::DEF_MAX_PARTICLES,
  parameter int MAX_DIMS      = pso_pkg::DEF_MAX_DIMS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pso_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  pso_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             rsp_push,
  input  logic             rsp_full,
  output pso_pkg::result_t rsp_data
);

  localparam int DEPTH = MAX_PARTICLES * MAX_DIMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW    = $clog2(MAX_DIMS + 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_EXEC = 10'b0000000010,
    S_GB   = 10'b0000000100,
    S_MUL  = 10'b0000001000,
    S_SUM  = 10'b0000010000,
    S_WB   = 10'b0000100000,
    S_FCMP = 10'b0001000000,
    S_CRD  = 10'b0010000000,
    S_CWR  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] pos_mem  [DEPTH];
  logic signed [31:0] vel_mem  [DEPTH];
  logic signed [31:0] bpos_mem [DEPTH];
  logic [31:0]        bfit_mem [MAX_PARTICLES];

  pso_pkg::item_t     item_r;
  logic [AW-1:0]      a_r, base_r;
  logic [PW-1:0]      p_r;
  logic [CW-1:0]      k_r, n_r;
  logic [15:0]        gw_r;
  logic [17:0]        gl_r, gs_r;
  logic signed [31:0] x_r, v_r, pb_r, vel_r;
  logic signed [35:0] tw_r, tl_r, ts_r;
  logic signed [31:0] res_pos_r, res_vel_r;
  logic               res_bg_r, res_bl_r;

  logic [5:0]         leader_r;
  logic [31:0]        lfit_r;
  logic               lvalid_r;
  logic               vflag_r [MAX_PARTICLES];

  logic signed [31:0] pos_q, vel_q, bpos_q;
  logic [31:0]        bfit_q;

  logic               do_load, do_fit, do_upd, better, lead_better;
  logic [AW-1:0]      copy_a, gaddr, pos_ra, bpos_ra, bpos_wa;
  logic               pos_we, bpos_we, bfit_we;
  logic signed [31:0] pos_wd, bpos_wd, gb, pos_new;
  logic [CW-1:0]      n_sel, k_inc;

  assign do_load = (state_r == S_EXEC) && item_r.in_range && (item_r.cmd == pso_pkg::CMD_LOAD);
  assign do_fit  = (state_r == S_EXEC) && item_r.in_range && (item_r.cmd == pso_pkg::CMD_FIT);
  assign do_upd  = (state_r == S_EXEC) && item_r.in_range && (item_r.cmd == pso_pkg::CMD_UPD);
  assign lead_better = !lvalid_r || (item_r.fitness < lfit_r);
  assign better  = !vflag_r[p_r] || (item_r.fitness < bfit_q);
  assign copy_a  = base_r + AW'(k_r);
  assign gaddr   = AW'(int'(leader_r) * MAX_DIMS + int'(item_r.dimension));
  assign k_inc   = k_r + CW'(1);
  assign n_sel   = (int'(cfg.dims_in_use) > MAX_DIMS) ? CW'(MAX_DIMS) : CW'(cfg.dims_in_use);
  assign gb      = lvalid_r ? bpos_q : 32'sd0;

  // new position: saturate, then clamp high before low so low wins
  always_comb begin
    pos_new = pso_pkg::sat32(38'(x_r) + 38'(vel_r));
    if (cfg.clamp_enable && item_r.clamp_slot) begin
      if (pos_new > cfg.clamp_high) pos_new = cfg.clamp_high;
      if (pos_new < cfg.clamp_low) pos_new = cfg.clamp_low;
    end
  end

  assign pos_ra  = (state_r == S_CRD) ? copy_a : a_r;
  assign pos_we  = do_load || (state_r == S_WB);
  assign pos_wd  = do_load ? item_r.load_value : pos_new;
  assign bpos_ra = (state_r == S_GB) ? gaddr : a_r;
  assign bpos_we = do_load || (state_r == S_CWR);
  assign bpos_wa = (state_r == S_CWR) ? copy_a : a_r;
  assign bpos_wd = (state_r == S_CWR) ? pos_q : item_r.load_value;
  assign bfit_we = (state_r == S_FCMP) && better;

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[a_r] <= pos_wd;
    pos_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (pos_we) vel_mem[a_r] <= do_load ? 32'sd0 : vel_r;
    vel_q <= vel_mem[a_r];
  end

  always_ff @(posedge clk) begin
    if (bpos_we) bpos_mem[bpos_wa] <= bpos_wd;
    bpos_q <= bpos_mem[bpos_ra];
  end

  always_ff @(posedge clk) begin
    if (bfit_we) bfit_mem[p_r] <= item_r.fitness;
    bfit_q <= bfit_mem[p_r];
  end

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign rsp_push = (state_r == S_OUT) && !rsp_full;
  always_comb begin
    rsp_data.new_position  = res_pos_r;
    rsp_data.new_velocity  = res_vel_r;
    rsp_data.became_global = res_bg_r;
    rsp_data.became_local  = res_bl_r;
    rsp_data.leader        = leader_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (do_fit) state_nxt = S_FCMP;
        else if (do_upd) state_nxt = S_GB;
        else state_nxt = S_OUT;
      end
      S_GB:   state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_WB;
      S_WB:   state_nxt = S_OUT;
      S_FCMP: state_nxt = (better && (n_r != '0)) ? S_CRD : S_OUT;
      S_CRD:  state_nxt = S_CWR;
      S_CWR:  state_nxt = (k_inc == n_r) ? S_OUT : S_CRD;
      S_OUT:  if (!rsp_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      leader_r <= 6'd0;
      lfit_r   <= 32'd0;
      lvalid_r <= 1'b0;
      for (int i = 0; i < MAX_PARTICLES; i++) vflag_r[i] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_load) vflag_r[p_r] <= 1'b0;
      if (do_fit && lead_better) begin
        lvalid_r <= 1'b1;
        lfit_r   <= item_r.fitness;
        leader_r <= item_r.particle;
      end
      if (bfit_we) vflag_r[p_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        item_r <= q_item;
        a_r    <= AW'(int'(q_item.particle) * MAX_DIMS + int'(q_item.dimension));
        base_r <= AW'(int'(q_item.particle) * MAX_DIMS);
        p_r    <= PW'(q_item.particle);
      end
      S_EXEC: begin
        res_pos_r <= do_load ? item_r.load_value : 32'sd0;
        res_vel_r <= 32'sd0;
        res_bg_r  <= do_fit && lead_better;
        res_bl_r  <= 1'b0;
        n_r       <= n_sel;
        k_r       <= '0;
        gw_r      <= 16'((32'(cfg.inertia_gain) * 32'(item_r.rand_inertia)) >> 16);
        gl_r      <= 18'((34'(cfg.local_gain) * 34'(item_r.rand_local)) >> 16);
        gs_r      <= 18'((34'(cfg.social_gain) * 34'(item_r.rand_social)) >> 16);
      end
      S_GB: begin
        x_r  <= pos_q;
        v_r  <= vel_q;
        pb_r <= bpos_q;
      end
      S_MUL: begin
        tw_r <= 36'((52'($signed({3'b0, gw_r})) * 52'(v_r)) >>> 16);
        tl_r <= 36'((52'($signed({1'b0, gl_r})) * (52'(pb_r) - 52'(x_r))) >>> 16);
        ts_r <= 36'((52'($signed({1'b0, gs_r})) * (52'(gb) - 52'(x_r))) >>> 16);
      end
      S_SUM: vel_r <= pso_pkg::sat32(38'(tw_r) + 38'(tl_r) + 38'(ts_r));
      S_WB: begin
        res_pos_r <= pos_new;
        res_vel_r <= vel_r;
      end
      S_FCMP: if (better) res_bl_r <= 1'b1;
      S_CWR: k_r <= k_inc;
      default: ;
    endcase
  end

endmodule

/* rtl/core/pso_swarm_update_engine.sv */
// Steps per item: a load or no-op is executed and then output; an update reads the
// stores, multiplies, sums and writes back; a fitness item compares and, on a new best,
// copies min(dims_in_use, MAX_DIMS) dimensions. One item at a time: the back end takes
// no new item until the last one is output. Two-deep queues each side.
// Reset (rst_n low, synchronous) empties the queues, clears the valid flags and
// the leader and restores register defaults; the element stores are not cleared.
module pso_swarm_update_engine #(
  parameter int MAX_PARTICLES = pso_pkg::DEF_MAX_PARTICLES,
  parameter int MAX_DIMS      = pso_pkg::DEF_MAX_DIMS,
  parameter int GROUP_STRIDE  = pso_pkg::DEF_GROUP_STRIDE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_command,
  input  logic [5:0]         in_particle,
  input  logic [5:0]         in_dimension,
  input  logic signed [31:0] in_load_value,
  input  logic [31:0]        in_fitness,
  input  logic [15:0]        in_rand_inertia,
  input  logic [15:0]        in_rand_local,
  input  logic [15:0]        in_rand_social,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_new_position,
  output logic signed [31:0] out_new_velocity,
  output logic               out_became_global,
  output logic               out_became_local,
  output logic [5:0]         out_leader,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  pso_pkg::cfg_t    cfg_r;
  pso_pkg::item_t   q_item;
  pso_pkg::result_t rsp_data, out_data;
  logic             q_valid, q_pop, rsp_push, rsp_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inertia_gain <= pso_pkg::RST_INERTIA;
      cfg_r.local_gain   <= pso_pkg::RST_LOCAL;
      cfg_r.social_gain  <= pso_pkg::RST_SOCIAL;
      cfg_r.clamp_low    <= pso_pkg::RST_CLAMP_LO;
      cfg_r.clamp_high   <= pso_pkg::RST_CLAMP_HI;
      cfg_r.clamp_enable <= pso_pkg::RST_CLAMP_EN;
      cfg_r.dims_in_use  <= pso_pkg::RST_DIMS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pso_pkg::REG_INERTIA:  cfg_r.inertia_gain <= cfg_data[15:0];
        pso_pkg::REG_LOCAL:    cfg_r.local_gain   <= cfg_data[17:0];
        pso_pkg::REG_SOCIAL:   cfg_r.social_gain  <= cfg_data[17:0];
        pso_pkg::REG_CLAMP_LO: cfg_r.clamp_low    <= cfg_data;
        pso_pkg::REG_CLAMP_HI: cfg_r.clamp_high   <= cfg_data;
        pso_pkg::REG_CLAMP_EN: cfg_r.clamp_enable <= cfg_data[0];
        pso_pkg::REG_DIMS:     cfg_r.dims_in_use  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  pso_front #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .MAX_DIMS     (MAX_DIMS),
    .GROUP_STRIDE (GROUP_STRIDE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_particle    (in_particle),
    .in_dimension   (in_dimension),
    .in_load_value  (in_load_value),
    .in_fitness     (in_fitness),
    .in_rand_inertia(in_rand_inertia),
    .in_rand_local  (in_rand_local),
    .in_rand_social (in_rand_social),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  pso_back #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .MAX_DIMS     (MAX_DIMS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .rsp_push(rsp_push),
    .rsp_full(rsp_full),
    .rsp_data(rsp_data)
  );

  pso_rsp_queue u_rsp (
    .clk      (clk),
    .rst_n    (rst_n),
    .rsp_push (rsp_push),
    .rsp_full (rsp_full),
    .rsp_data (rsp_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  assign out_new_position  = out_data.new_position;
  assign out_new_velocity  = out_data.new_velocity;
  assign out_became_global = out_data.became_global;
  assign out_became_local  = out_data.became_local;
  assign out_leader        = out_data.leader;

endmodule

/* rtl/core/pso_checker.sv */
module pso_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [31:0] out_new_position,
  input logic signed [31:0] out_new_velocity,
  input logic               out_became_global,
  input logic               out_became_local
);

  // a waiting word holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_new_position)))
    else $error("result word changed while waiting");

  // reset leaves the result queue empty and the input queue not full
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // fitness flags only come with zero position and velocity
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_became_global || out_became_local)) |->
      (out_new_position == 32'sd0 && out_new_velocity == 32'sd0))
    else $error("fitness result carries position or velocity");

endmodule

bind pso_swarm_update_engine pso_checker u_pso_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_new_position (out_new_position),
  .out_new_velocity (out_new_velocity),
  .out_became_global(out_became_global),
  .out_became_local (out_became_local)
);
